// File: design/tes_pkg.sv
// Shared types, constants and a helper function of the tetrahedral element stiffness core.
`timescale 1ns / 1ps
package tes_pkg;

   // Width of one node gradient component (sum of three Q16.16 values).
   localparam int unsigned GW = 34;

   localparam logic [31:0] YOUNG_RESET   = 32'd100000;
   localparam logic [14:0] POISSON_RESET = 15'd19661;
   localparam logic [63:0] Q16_ONE       = 64'h0000_0000_0001_0000;
   localparam logic [63:0] S64_MAX       = 64'h7fff_ffff_ffff_ffff;
   localparam logic [63:0] S64_MIN       = 64'h8000_0000_0000_0000;

   localparam logic REG_YOUNG   = 1'b0;
   localparam logic REG_POISSON = 1'b1;

   typedef enum logic [1:0] {
      PASS_BD,
      PASS_KE,
      PASS_P
   } tes_pass_type;

   typedef struct packed {
      tes_pass_type pass;
      logic         first;
      logic         last_term;
      logic [3:0]   row;
      logic [2:0]   col;
      logic         half;
      logic         elem_last;
   } tes_tag_type;

   typedef struct packed {
      logic [11:0][GW-1:0] g;
      logic [31:0]         vol;
   } tes_elem_type;

   typedef struct packed {
      logic [63:0] lam;
      logic [63:0] mu;
      logic [63:0] diag;
   } tes_lame_type;

   typedef enum logic [2:0] {
      LAME_MUL,
      LAME_LAM,
      LAME_MU,
      LAME_SUM,
      LAME_DONE
   } tes_lame_state_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_BD,
      SEQ_KE,
      SEQ_P
   } tes_seq_state_type;

   // Saturating signed 64-bit addition.
   function automatic logic [63:0] tes_sadd(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] s;
      s = a + b;
      if (!a[63] && !b[63] && s[63]) begin
         return S64_MAX;
      end
      if (a[63] && b[63] && !s[63]) begin
         return S64_MIN;
      end
      return s;
   endfunction

endpackage

// File: design/tes_lame.sv
// Lame term unit: a bit-serial divider that derives lambda, mu and lambda + 2 mu.
`timescale 1ns / 1ps
module tes_lame
   import tes_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         restart,
   input  logic [31:0]  young,
   input  logic [14:0]  poisson,
   output logic         busy,
   output tes_lame_type lame
);

   tes_lame_state_type state_ff, state_in;
   logic [6:0]  cnt_ff;
   logic [79:0] dvd_ff;
   logic [32:0] div_ff;
   logic [32:0] rem_ff;
   logic [63:0] quo_ff;
   logic [63:0] lam_ff, mu_ff, diag_ff;

   logic [46:0] q_w;
   logic [33:0] den_w;
   logic [33:0] trial_w;
   logic        ge_w;
   logic [32:0] rem_w;
   logic [63:0] quo_w;
   logic        step_end_w;

   assign q_w     = 47'(young) * 47'(poisson);
   assign den_w   = 34'(17'h10000 + 17'(poisson)) * 34'(17'h10000 - {1'b0, poisson, 1'b0});
   assign trial_w = {rem_ff, dvd_ff[79]};
   assign ge_w    = trial_w >= {1'b0, div_ff};
   assign rem_w   = ge_w ? 33'(trial_w - {1'b0, div_ff}) : trial_w[32:0];
   assign quo_w   = {quo_ff[62:0], ge_w};
   assign step_end_w = cnt_ff == 7'd79;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         LAME_MUL:  state_in = LAME_LAM;
         LAME_LAM:  if (step_end_w) state_in = LAME_MU;
         LAME_MU:   if (step_end_w) state_in = LAME_SUM;
         LAME_SUM:  state_in = LAME_DONE;
         LAME_DONE: state_in = LAME_DONE;
         default:   state_in = LAME_MUL;
      endcase
      if (restart) begin
         state_in = LAME_MUL;
      end
   end

   always_comb begin
      busy = state_ff != LAME_DONE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LAME_MUL;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         LAME_MUL: begin
            dvd_ff <= {1'b0, q_w, 32'd0};
            div_ff <= den_w[32:0];
            rem_ff <= '0;
            cnt_ff <= '0;
         end
         LAME_LAM, LAME_MU: begin
            quo_ff <= quo_w;
            if (step_end_w && state_ff == LAME_LAM) begin
               lam_ff <= quo_w;
               dvd_ff <= {17'd0, young, 31'd0};
               div_ff <= {16'd0, 17'(17'h10000 + 17'(poisson))};
               rem_ff <= '0;
               cnt_ff <= '0;
            end else begin
               dvd_ff <= {dvd_ff[78:0], 1'b0};
               rem_ff <= rem_w;
               cnt_ff <= cnt_ff + 7'd1;
               if (step_end_w) begin
                  mu_ff <= quo_w;
               end
            end
         end
         LAME_SUM: diag_ff <= lam_ff + {mu_ff[62:0], 1'b0};
         default: ;
      endcase
   end

   assign lame.lam  = lam_ff;
   assign lame.mu   = mu_ff;
   assign lame.diag = diag_ff;

endmodule

// File: design/tes_front.sv
// Front end: takes requests, forms the node gradients and queues elements.
`timescale 1ns / 1ps
module tes_front
   import tes_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [8:0][31:0]  m_all,
   input  logic [31:0]       volume,
   input  logic              lame_busy,
   input  logic              pop,
   output logic              busy,
   output logic              head_valid,
   output tes_elem_type      head
);

   tes_elem_type q_mem_ff [2];
   logic         wr_ptr_ff, rd_ptr_ff;
   logic [1:0]   count_ff;
   logic         push_w;
   tes_elem_type elem_w;

   assign busy   = reset || lame_busy || (count_ff == 2'd2);
   assign push_w = start && !busy;

   always_comb begin
      elem_w.vol = volume;
      for (int c = 0; c < 3; c++) begin
         elem_w.g[c] = GW'(signed'(m_all[c])) + GW'(signed'(m_all[3 + c]))
                     + GW'(signed'(m_all[6 + c]));
         for (int k = 1; k < 4; k++) begin
            elem_w.g[3 * k + c] = GW'(0) - GW'(signed'(m_all[3 * (k - 1) + c]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push_w) begin
         q_mem_ff[wr_ptr_ff] <= elem_w;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (push_w) wr_ptr_ff <= !wr_ptr_ff;
         if (pop) rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + 2'(push_w) - 2'(pop);
      end
   end

   assign head_valid = count_ff != 2'd0;
   assign head       = q_mem_ff[rd_ptr_ff];

endmodule

// File: design/tes_qmul.sv
// Pipelined Q.16 signed product with truncation toward zero and saturation.
`timescale 1ns / 1ps
module tes_qmul
   import tes_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [63:0] in_x,
   input  logic [63:0] in_y,
   input  tes_tag_type in_tag,
   output logic        out_valid,
   output logic [63:0] out_p,
   output tes_tag_type out_tag
);

   logic [3:0]   valid_ff;
   logic [63:0]  mx_ff, my_ff;
   logic [63:0]  pl_ff, pm1_ff, pm2_ff, ph_ff;
   logic [127:0] prod_ff;
   logic [63:0]  p_ff;
   logic         neg1_ff, neg2_ff, neg3_ff;
   tes_tag_type  tag1_ff, tag2_ff, tag3_ff, tag4_ff;
   logic [63:0]  r_w, sat_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
   end

   assign r_w = prod_ff[79:16];

   always_comb begin
      if (|prod_ff[127:80]) begin
         sat_w = neg3_ff ? S64_MIN : S64_MAX;
      end else if (neg3_ff) begin
         sat_w = r_w[63] ? S64_MIN : 64'd0 - r_w;
      end else begin
         sat_w = r_w[63] ? S64_MAX : r_w;
      end
   end

   always_ff @(posedge clock) begin
      mx_ff   <= in_x[63] ? 64'd0 - in_x : in_x;
      my_ff   <= in_y[63] ? 64'd0 - in_y : in_y;
      neg1_ff <= in_x[63] ^ in_y[63];
      tag1_ff <= in_tag;

      pl_ff   <= 64'(mx_ff[31:0]) * 64'(my_ff[31:0]);
      pm1_ff  <= 64'(mx_ff[63:32]) * 64'(my_ff[31:0]);
      pm2_ff  <= 64'(mx_ff[31:0]) * 64'(my_ff[63:32]);
      ph_ff   <= 64'(mx_ff[63:32]) * 64'(my_ff[63:32]);
      neg2_ff <= neg1_ff;
      tag2_ff <= tag1_ff;

      prod_ff <= {ph_ff, pl_ff} + {32'd0, pm1_ff, 32'd0} + {32'd0, pm2_ff, 32'd0};
      neg3_ff <= neg2_ff;
      tag3_ff <= tag2_ff;

      p_ff    <= sat_w;
      tag4_ff <= tag3_ff;
   end

   assign out_valid = valid_ff[3];
   assign out_p     = p_ff;
   assign out_tag   = tag4_ff;

endmodule

// File: design/tes_back.sv
// Back end: sequences the B^T*D, Ke and P sums through shared product pipelines.
`timescale 1ns / 1ps
module tes_back
   import tes_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  tes_elem_type      head,
   input  tes_lame_type      lame,
   output logic              pop,
   output logic              rsp_valid,
   output logic              rsp_kind,
   output logic [3:0]        rsp_row,
   output logic [2:0]        rsp_col_base,
   output logic [5:0][63:0]  rsp_v,
   output logic              rsp_last
);

   tes_seq_state_type state_ff, state_in;
   logic [3:0] ci_ff;
   logic       ch_ff;
   logic [2:0] cc_ff, ca_ff;
   logic [11:0][GW-1:0] g_ff;
   logic [31:0] vol_elem_ff, vol_act_ff;

   logic bd_end_w, ke_end_w, p_end_w, clear_w, issue_w, vol_load_w;

   // Issue stage
   logic        is_valid_ff, is_mem_ff;
   logic [63:0] is_bmx_ff, is_y_ff;
   tes_tag_type is_tag_ff;
   logic [63:0] bmx_w, y_w;
   tes_tag_type tag_w;
   logic [6:0]  rd_addr_w;

   logic [63:0] bd_mem [72];
   logic [63:0] bd_q_ff;

   logic        q1_valid, q2_valid;
   logic [63:0] q1_p, q2_p;
   tes_tag_type q1_tag, q2_tag;

   logic        acc_valid_ff;
   logic [63:0] acc_ff;
   tes_tag_type acc_tag_ff;
   logic [6:0]  wr_addr_w;

   logic [63:0] coll_ff [5];
   logic        rsp_valid_ff, rsp_kind_ff, rsp_last_ff;
   logic [3:0]  rsp_row_ff;
   logic [2:0]  rsp_col_base_ff;
   logic [5:0][63:0] rsp_v_ff;

   function automatic logic [63:0] bm_at(input logic [11:0][GW-1:0] g,
                                         input logic [2:0] a, input logic [3:0] col);
      logic [1:0]    k;
      logic [1:0]    p;
      logic [3:0]    base;
      logic [GW-1:0] gx, gy, gz, v;
      k    = (col >= 4'd9) ? 2'd3 : (col >= 4'd6) ? 2'd2 : (col >= 4'd3) ? 2'd1 : 2'd0;
      base = 4'({2'd0, k} * 4'd3);
      p    = 2'(col - base);
      gx   = g[base];
      gy   = g[base + 4'd1];
      gz   = g[base + 4'd2];
      v    = '0;
      case (p)
         2'd0: v = (a == 3'd0) ? gx : (a == 3'd3) ? gy : (a == 3'd4) ? gz : '0;
         2'd1: v = (a == 3'd1) ? gy : (a == 3'd3) ? gx : (a == 3'd5) ? gz : '0;
         2'd2: v = (a == 3'd2) ? gz : (a == 3'd4) ? gx : (a == 3'd5) ? gy : '0;
         default: v = '0;
      endcase
      return {{(64 - GW){v[GW-1]}}, v};
   endfunction

   function automatic logic [63:0] dmat_at(input tes_lame_type l,
                                           input logic [2:0] a, input logic [2:0] j);
      if (a < 3'd3 && j < 3'd3) begin
         return (a == j) ? l.diag : l.lam;
      end
      return (a == j) ? l.mu : 64'd0;
   endfunction

   assign bd_end_w = ca_ff == 3'd5 && cc_ff == 3'd5 && ci_ff == 4'd11;
   assign ke_end_w = bd_end_w && ch_ff;
   assign p_end_w  = cc_ff == 3'd5 && ci_ff == 4'd11;

   // Sequencer next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SEQ_IDLE: if (head_valid) state_in = SEQ_BD;
         SEQ_BD:   if (bd_end_w) state_in = SEQ_KE;
         SEQ_KE:   if (ke_end_w) state_in = SEQ_P;
         SEQ_P:    if (p_end_w) state_in = head_valid ? SEQ_BD : SEQ_IDLE;
         default:  state_in = SEQ_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      pop        = head_valid && (state_ff == SEQ_IDLE || (state_ff == SEQ_P && p_end_w));
      issue_w    = state_ff != SEQ_IDLE;
      vol_load_w = state_ff == SEQ_BD && bd_end_w;
      clear_w    = pop || vol_load_w || (state_ff == SEQ_KE && ke_end_w)
                 || (state_ff == SEQ_P && p_end_w);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         ci_ff    <= '0;
         ch_ff    <= 1'b0;
         cc_ff    <= '0;
         ca_ff    <= '0;
      end else begin
         state_ff <= state_in;
         if (clear_w) begin
            ci_ff <= '0;
            ch_ff <= 1'b0;
            cc_ff <= '0;
            ca_ff <= '0;
         end else begin
            case (state_ff)
               SEQ_BD, SEQ_KE: begin
                  ca_ff <= (ca_ff == 3'd5) ? 3'd0 : ca_ff + 3'd1;
                  if (ca_ff == 3'd5) begin
                     cc_ff <= (cc_ff == 3'd5) ? 3'd0 : cc_ff + 3'd1;
                     if (cc_ff == 3'd5) begin
                        if (state_ff == SEQ_KE) begin
                           ch_ff <= !ch_ff;
                           if (ch_ff) ci_ff <= ci_ff + 4'd1;
                        end else begin
                           ci_ff <= ci_ff + 4'd1;
                        end
                     end
                  end
               end
               SEQ_P: begin
                  cc_ff <= (cc_ff == 3'd5) ? 3'd0 : cc_ff + 3'd1;
                  if (cc_ff == 3'd5) ci_ff <= ci_ff + 4'd1;
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         g_ff        <= head.g;
         vol_elem_ff <= head.vol;
      end
      if (vol_load_w) begin
         vol_act_ff <= vol_elem_ff;
      end
   end

   // Operand selection
   always_comb begin
      bmx_w         = bm_at(g_ff, ca_ff, ci_ff);
      tag_w.pass    = PASS_BD;
      tag_w.first   = ca_ff == 3'd0;
      tag_w.last_term = ca_ff == 3'd5;
      tag_w.row     = ci_ff;
      tag_w.col     = cc_ff;
      tag_w.half    = ch_ff;
      tag_w.elem_last = 1'b0;
      rd_addr_w     = 7'(7'(ci_ff) * 7'd6) + 7'(ca_ff);
      case (state_ff)
         SEQ_KE: begin
            tag_w.pass = PASS_KE;
            y_w = bm_at(g_ff, ca_ff, (ch_ff ? 4'd6 : 4'd0) + 4'(cc_ff));
         end
         SEQ_P: begin
            tag_w.pass      = PASS_P;
            tag_w.first     = 1'b1;
            tag_w.last_term = 1'b1;
            tag_w.elem_last = p_end_w;
            rd_addr_w       = 7'(7'(ci_ff) * 7'd6) + 7'(cc_ff);
            y_w             = Q16_ONE;
         end
         default: y_w = dmat_at(lame, ca_ff, cc_ff);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         is_valid_ff <= 1'b0;
      end else begin
         is_valid_ff <= issue_w;
      end
      is_mem_ff <= state_ff != SEQ_BD;
      is_bmx_ff <= bmx_w;
      is_y_ff   <= y_w;
      is_tag_ff <= tag_w;
   end

   assign wr_addr_w = 7'(7'(acc_tag_ff.row) * 7'd6) + 7'(acc_tag_ff.col);

   always_ff @(posedge clock) begin
      bd_q_ff <= bd_mem[rd_addr_w];
      if (acc_valid_ff && acc_tag_ff.pass == PASS_BD) begin
         bd_mem[wr_addr_w] <= acc_ff;
      end
   end

   tes_qmul u_qmul_sum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (is_valid_ff),
      .in_x      (is_mem_ff ? bd_q_ff : is_bmx_ff),
      .in_y      (is_y_ff),
      .in_tag    (is_tag_ff),
      .out_valid (q1_valid),
      .out_p     (q1_p),
      .out_tag   (q1_tag)
   );

   // Running sum in issue order, saturating at every addition.
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_valid_ff <= 1'b0;
      end else begin
         acc_valid_ff <= q1_valid && q1_tag.last_term;
      end
      if (q1_valid) begin
         acc_ff     <= tes_sadd(q1_tag.first ? 64'd0 : acc_ff, q1_p);
         acc_tag_ff <= q1_tag;
      end
   end

   tes_qmul u_qmul_vol (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (acc_valid_ff && acc_tag_ff.pass != PASS_BD),
      .in_x      (acc_ff),
      .in_y      ({32'd0, vol_act_ff}),
      .in_tag    (acc_tag_ff),
      .out_valid (q2_valid),
      .out_p     (q2_p),
      .out_tag   (q2_tag)
   );

   // Gather six values and present them for one cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= q2_valid && q2_tag.col == 3'd5;
      end
      if (q2_valid && q2_tag.col < 3'd5) begin
         coll_ff[q2_tag.col] <= q2_p;
      end
      if (q2_valid && q2_tag.col == 3'd5) begin
         for (int c = 0; c < 5; c++) begin
            rsp_v_ff[c] <= coll_ff[c];
         end
         rsp_v_ff[5]     <= q2_p;
         rsp_kind_ff     <= q2_tag.pass == PASS_P;
         rsp_row_ff      <= q2_tag.row;
         rsp_col_base_ff <= q2_tag.half ? 3'd6 : 3'd0;
         rsp_last_ff     <= q2_tag.elem_last;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_kind     = rsp_kind_ff;
   assign rsp_row      = rsp_row_ff;
   assign rsp_col_base = rsp_col_base_ff;
   assign rsp_v        = rsp_v_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

// File: design/tetra_element_stiffness_core.sv
// Top level of the tetrahedral element stiffness core with its register port.
// Each element passes through the single summing product pipeline
// (432 B^T*D products, 864 Ke products and 72 P products, one issued per cycle).
// The Ke results of an element come first and its P results follow. Results cannot be stalled.
// Reset is synchronous; after reset and after every register write busy stays high
// while the Lame terms are recomputed by the serial divider.
`timescale 1ns / 1ps
module tetra_element_stiffness_core
   import tes_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Request channel
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_m00,
   input  logic [31:0] req_m01,
   input  logic [31:0] req_m02,
   input  logic [31:0] req_m10,
   input  logic [31:0] req_m11,
   input  logic [31:0] req_m12,
   input  logic [31:0] req_m20,
   input  logic [31:0] req_m21,
   input  logic [31:0] req_m22,
   input  logic [31:0] req_volume,
   // Result channel
   output logic        rsp_valid,
   output logic        rsp_kind,
   output logic [3:0]  rsp_row,
   output logic [2:0]  rsp_col_base,
   output logic [63:0] rsp_v0,
   output logic [63:0] rsp_v1,
   output logic [63:0] rsp_v2,
   output logic [63:0] rsp_v3,
   output logic [63:0] rsp_v4,
   output logic [63:0] rsp_v5,
   output logic        rsp_last,
   // Register port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   // Young modulus sits at byte address 0 and Poisson ratio at 4; only address bit 2 decodes.
   logic [31:0] young_ff;
   logic [14:0] poisson_ff;
   logic        csr_wr_w;

   logic         lame_busy, front_busy, head_valid, pop;
   tes_elem_type head;
   tes_lame_type lame;
   logic [8:0][31:0] m_all;
   logic [5:0][63:0] rsp_v;

   assign pready   = 1'b1;
   assign csr_wr_w = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         young_ff   <= YOUNG_RESET;
         poisson_ff <= POISSON_RESET;
      end else if (csr_wr_w) begin
         case (paddr[2])
            REG_YOUNG:   young_ff   <= pwdata;
            REG_POISSON: poisson_ff <= pwdata[14:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_POISSON: prdata = {17'd0, poisson_ff};
         default:     prdata = young_ff;
      endcase
   end

   // Any register write restarts the Lame term computation with the new values.
   tes_lame u_lame (
      .clock   (clock),
      .reset   (reset),
      .restart (csr_wr_w),
      .young   (young_ff),
      .poisson (poisson_ff),
      .busy    (lame_busy),
      .lame    (lame)
   );

   assign m_all = {req_m22, req_m21, req_m20, req_m12, req_m11, req_m10,
                   req_m02, req_m01, req_m00};

   // The front end holds up to two elements, so a new request is taken while
   // the back end is still working on an earlier one.
   tes_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .m_all      (m_all),
      .volume     (req_volume),
      .lame_busy  (lame_busy),
      .pop        (pop),
      .busy       (front_busy),
      .head_valid (head_valid),
      .head       (head)
   );

   assign busy = front_busy;

   tes_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_valid   (head_valid),
      .head         (head),
      .lame         (lame),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_kind     (rsp_kind),
      .rsp_row      (rsp_row),
      .rsp_col_base (rsp_col_base),
      .rsp_v        (rsp_v),
      .rsp_last     (rsp_last)
   );

   assign rsp_v0 = rsp_v[0];
   assign rsp_v1 = rsp_v[1];
   assign rsp_v2 = rsp_v[2];
   assign rsp_v3 = rsp_v[3];
   assign rsp_v4 = rsp_v[4];
   assign rsp_v5 = rsp_v[5];

endmodule

// File: design/tes_port_checker.sv
// Port-level checks of the tetrahedral element stiffness core, bound to its top level.
`timescale 1ns / 1ps
module tes_port_checker (
   input logic       clock,
   input logic       reset,
   input logic       busy,
   input logic       rsp_valid,
   input logic       rsp_kind,
   input logic [3:0] rsp_row,
   input logic [2:0] rsp_col_base,
   input logic       rsp_last
);

   a_busy_after_reset: assert property (@(posedge clock) reset |=> busy)
      else $error("busy low right after reset");

   a_row_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_row <= 4'd11)
      else $error("result row out of range");

   a_proj_col: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind |-> rsp_col_base == 3'd0)
      else $error("projection row with nonzero column base");

   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_kind && rsp_row == 4'd11)
      else $error("last flag on wrong result");

   a_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("results on consecutive cycles");

endmodule

bind tetra_element_stiffness_core tes_port_checker u_port_checker (.*);

// File: tb/sv/tetra_element_stiffness_core_tb.sv
// Self-checking testbench of the tetrahedral element stiffness core.
`timescale 1ns / 1ps
module tetra_element_stiffness_core_tb;
   import tes_pkg::*;

   localparam int WATCHDOG_LIMIT = 6000;
   localparam int SETTLE_CYCLES  = 60;
   localparam logic KIND_KE = 1'b0;
   localparam logic KIND_P  = 1'b1;

   typedef struct {
      logic [31:0] m[9];
      logic [31:0] volume;
   } element_type;

   typedef struct {
      logic        kind;
      logic [3:0]  row;
      logic [2:0]  col_base;
      logic [63:0] v[6];
      logic        last;
   } row_result_type;

   // Predicts the stiffness and stress rows of each element and holds them until they arrive.
   class stiffness_scoreboard;
      longint lam_q16;
      longint mu_q16;
      row_result_type rows_due[$];
      int mismatches;

      function void set_material(logic [31:0] young, logic [14:0] poisson);
         bit [63:0] n, e, q, den;
         n = poisson;
         e = young;
         q = n * e;
         den = (64'd65536 + n) * (64'd65536 - 2 * n);
         lam_q16 = ((q / den) << 32) + (((q % den) << 32) / den);
         mu_q16 = (e << 31) / (64'd65536 + n);
      endfunction

      function longint fx_mul(longint a, longint b);
         logic signed [127:0] p, mag, r;
         p = 128'(signed'(a)) * 128'(signed'(b));
         mag = (p < 0) ? -p : p;
         r = mag >>> 16;
         if (p < 0) begin
            if (r >= (128'sd1 <<< 63)) return 64'h8000_0000_0000_0000;
            return -longint'(r[63:0]);
         end
         if (r > 128'sh7fff_ffff_ffff_ffff) return 64'h7fff_ffff_ffff_ffff;
         return longint'(r[63:0]);
      endfunction

      function longint sat_add(longint a, longint b);
         longint s;
         s = a + b;
         if (a >= 0 && b >= 0 && s < 0) return 64'h7fff_ffff_ffff_ffff;
         if (a < 0 && b < 0 && s >= 0) return 64'h8000_0000_0000_0000;
         return s;
      endfunction

      function longint elasticity(int a, int b);
         if (a < 3 && b < 3) return (a == b) ? lam_q16 + 2 * mu_q16 : lam_q16;
         if (a == b) return mu_q16;
         return 0;
      endfunction

      // Works out all 36 rows of one accepted element.
      function void note_element(element_type el);
         longint m[3][3];
         longint g[4][3];
         longint strain[6][12];
         longint bd[12][6];
         longint vol, s;
         row_result_type r;
         for (int i = 0; i < 9; i++) m[i / 3][i % 3] = longint'(signed'(el.m[i]));
         vol = longint'({32'd0, el.volume});
         for (int c = 0; c < 3; c++) begin
            g[0][c] = m[0][c] + m[1][c] + m[2][c];
            for (int k = 1; k < 4; k++) g[k][c] = -m[k - 1][c];
         end
         foreach (strain[a, j]) strain[a][j] = 0;
         for (int k = 0; k < 4; k++) begin
            strain[0][3*k] = g[k][0];     strain[3][3*k] = g[k][1];
            strain[4][3*k] = g[k][2];     strain[1][3*k+1] = g[k][1];
            strain[3][3*k+1] = g[k][0];   strain[5][3*k+1] = g[k][2];
            strain[2][3*k+2] = g[k][2];   strain[4][3*k+2] = g[k][0];
            strain[5][3*k+2] = g[k][1];
         end
         for (int i = 0; i < 12; i++)
            for (int j = 0; j < 6; j++) begin
               s = 0;
               for (int a = 0; a < 6; a++)
                  s = sat_add(s, fx_mul(strain[a][i], elasticity(a, j)));
               bd[i][j] = s;
            end
         for (int i = 0; i < 12; i++)
            for (int h = 0; h < 2; h++) begin
               r.kind = KIND_KE;
               r.row = 4'(i);
               r.col_base = 3'(6 * h);
               r.last = 1'b0;
               for (int c = 0; c < 6; c++) begin
                  s = 0;
                  for (int a = 0; a < 6; a++)
                     s = sat_add(s, fx_mul(bd[i][a], strain[a][6*h+c]));
                  r.v[c] = fx_mul(vol, s);
               end
               rows_due.push_back(r);
            end
         for (int i = 0; i < 12; i++) begin
            r.kind = KIND_P;
            r.row = 4'(i);
            r.col_base = 3'd0;
            r.last = (i == 11);
            for (int c = 0; c < 6; c++) r.v[c] = fx_mul(vol, bd[i][c]);
            rows_due.push_back(r);
         end
      endfunction

      function void report(string what, logic [63:0] want, logic [63:0] got);
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch %s: expected %h actual %h", what, want, got);
      endfunction

      function void check_row(row_result_type got);
         row_result_type want;
         if (rows_due.size() == 0) begin
            report("unexpected row", 64'd0, 64'({got.kind, got.row}));
            return;
         end
         want = rows_due.pop_front();
         if (got.kind !== want.kind) report("kind", 64'(want.kind), 64'(got.kind));
         if (got.row !== want.row) report("row", 64'(want.row), 64'(got.row));
         if (got.col_base !== want.col_base)
            report("col_base", 64'(want.col_base), 64'(got.col_base));
         if (got.last !== want.last) report("last", 64'(want.last), 64'(got.last));
         for (int c = 0; c < 6; c++)
            if (got.v[c] !== want.v[c]) report($sformatf("v%0d", c), want.v[c], got.v[c]);
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [31:0] req_m[9];
   logic [31:0] req_volume;
   logic        rsp_valid;
   logic        rsp_kind;
   logic [3:0]  rsp_row;
   logic [2:0]  rsp_col_base;
   logic [63:0] rsp_v[6];
   logic        rsp_last;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   stiffness_scoreboard board;
   int idle_cycles;

   tetra_element_stiffness_core i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_m00(req_m[0]), .req_m01(req_m[1]), .req_m02(req_m[2]),
      .req_m10(req_m[3]), .req_m11(req_m[4]), .req_m12(req_m[5]),
      .req_m20(req_m[6]), .req_m21(req_m[7]), .req_m22(req_m[8]),
      .req_volume(req_volume),
      .rsp_valid(rsp_valid), .rsp_kind(rsp_kind), .rsp_row(rsp_row),
      .rsp_col_base(rsp_col_base),
      .rsp_v0(rsp_v[0]), .rsp_v1(rsp_v[1]), .rsp_v2(rsp_v[2]),
      .rsp_v3(rsp_v[3]), .rsp_v4(rsp_v[4]), .rsp_v5(rsp_v[5]),
      .rsp_last(rsp_last),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // Results cannot be stalled, so every strobe is checked at the edge that ends it.
   // The watchdog counts edges at which neither a request nor a result moves.
   always @(posedge clock) begin
      row_result_type got;
      if (!reset && rsp_valid) begin
         got.kind = rsp_kind;
         got.row = rsp_row;
         got.col_base = rsp_col_base;
         got.last = rsp_last;
         for (int c = 0; c < 6; c++) got.v[c] = rsp_v[c];
         board.check_row(got);
      end
      if (reset || rsp_valid || (start && !busy)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Offers one element after a random gap and returns at the edge that accepts it.
   // Start is left high so that a following request with no gap keeps it asserted.
   task automatic send_element(element_type el);
      int gap;
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      for (int i = 0; i < 9; i++) req_m[i] <= el.m[i];
      req_volume <= el.volume;
      do @(posedge clock); while (busy);
      board.note_element(el);
   endtask

   // Writes one register and reads it back; the core must be idle when this is called.
   task automatic write_register(logic index, logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      pwrite <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata !== ((index == REG_POISSON) ? (value & 32'h7fff) : value))
         board.report("register readback", 64'(value), 64'(prdata));
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Waits until every expected row has arrived.
   task automatic drain_rows();
      while (board.rows_due.size() != 0) @(posedge clock);
   endtask

   // Waits for every expected row, lets the core settle, then sets new material constants.
   task automatic set_material(logic [31:0] young, logic [31:0] poisson);
      start <= 1'b0;
      drain_rows();
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_register(REG_YOUNG, young);
      write_register(REG_POISSON, poisson);
      board.set_material(young, poisson[14:0]);
   endtask

   function automatic element_type fill_element(logic [31:0] value, logic [31:0] vol);
      element_type el;
      foreach (el.m[i]) el.m[i] = value;
      el.volume = vol;
      return el;
   endfunction

   // Most elements are shaped like real meshes: small gradients and modest volumes.
   // The rest use the full 32-bit range so every input bit toggles and saturation is hit.
   function automatic element_type random_element();
      element_type el;
      if ($urandom_range(0, 3) != 0) begin
         foreach (el.m[i]) el.m[i] = 32'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
         el.volume = $urandom_range(0, 1 << 18);
      end else begin
         foreach (el.m[i]) el.m[i] = $urandom;
         el.volume = $urandom;
      end
      return el;
   endfunction

   task automatic random_phase(int count);
      for (int n = 0; n < count; n++) send_element(random_element());
   endtask

   initial begin
      element_type el;
      board = new();
      board.set_material(YOUNG_RESET, POISSON_RESET);
      idle_cycles = 0;
      reset <= 1'b1;
      start <= 1'b0;
      foreach (req_m[i]) req_m[i] <= '0;
      req_volume <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed elements with the reset material: zero, identity, extremes of every field.
      send_element(fill_element(32'd0, 32'd0));
      el = fill_element(32'd0, 32'h0001_0000);
      el.m[0] = 32'h0001_0000;
      el.m[4] = 32'h0001_0000;
      el.m[8] = 32'h0001_0000;
      send_element(el);
      send_element(fill_element(32'h7fff_ffff, 32'hffff_ffff));
      send_element(fill_element(32'h8000_0000, 32'hffff_ffff));
      send_element(fill_element(32'h8000_0000, 32'h0000_0001));
      send_element(fill_element(32'hffff_ffff, 32'h0001_0000));
      send_element(fill_element(32'h0000_0001, 32'h0001_0000));
      el = fill_element(32'h7fff_ffff, 32'h0002_0000);
      el.m[3] = 32'h8000_0000;
      el.m[5] = 32'h8000_0000;
      send_element(el);
      send_element(fill_element(32'h0002_0000, 32'h0000_0000));
      random_phase(30);

      // Stiffest material with the Poisson ratio at its limit.
      set_material(32'hffff_ffff, 32'h0000_7fff);
      send_element(fill_element(32'h0001_0000, 32'h0001_0000));
      send_element(fill_element(32'h7fff_ffff, 32'hffff_ffff));
      random_phase(35);

      // Zero modulus gives an all-zero elasticity matrix; upper Poisson bits are dropped.
      set_material(32'd0, 32'hffff_8000);
      send_element(fill_element(32'h7fff_ffff, 32'hffff_ffff));
      random_phase(25);

      // Smallest modulus and a zero Poisson ratio.
      set_material(32'd1, 32'd0);
      send_element(fill_element(32'h8000_0000, 32'hffff_ffff));
      random_phase(35);

      for (int p = 0; p < 4; p++) begin
         set_material($urandom, $urandom);
         random_phase(35);
      end

      start <= 1'b0;
      drain_rows();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
